[rtl/core/sit_pkg.sv]
// Shared types and constants for the segment intersection test pipeline.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package sit_pkg;

	// Field positions in the input word, in coordinate units.
	localparam int NUM_FIELDS = 12;
	localparam int FLD_A_START = 0;
	localparam int FLD_A_END = 3;
	localparam int FLD_B_START = 6;
	localparam int FLD_B_END = 9;
	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;
	localparam int AXIS_Z = 2;
	localparam int NUM_ORIENT = 4;

	// Result word: intersects in bit 0, case code in bits 2:1.
	localparam int OUT_W = 8;

	typedef enum logic [1:0] {
		ORI_COLLINEAR = 2'd0,
		ORI_CW        = 2'd1,
		ORI_CCW       = 2'd2
	} ori_t;

	typedef enum logic [1:0] {
		CASE_NONE   = 2'd0,
		CASE_CROSS  = 2'd1,
		CASE_TOUCH  = 2'd2,
		CASE_REJECT = 2'd3
	} case_t;

	// Endpoint-inside-box flags for the four endpoint tests.
	typedef struct packed {
		logic bs_in_a;
		logic be_in_a;
		logic as_in_b;
		logic ae_in_b;
	} box_t;

	typedef struct packed {
		ori_t o1;
		ori_t o2;
		ori_t o3;
		ori_t o4;
	} orient_set_t;

endpackage

`default_nettype wire

[rtl/core/sit_front.sv]
// First pipeline stage: coordinate differences for the four cross products
// and the closed bounding-box tests in x, y and z. Depends on sit_pkg.
`default_nettype none

module sit_front #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         en_s1,
	input  wire logic signed [COORD_BITS-1:0] crd [sit_pkg::NUM_FIELDS],
	output logic signed [COORD_BITS:0]        dqx_s1 [sit_pkg::NUM_ORIENT],
	output logic signed [COORD_BITS:0]        dqy_s1 [sit_pkg::NUM_ORIENT],
	output logic signed [COORD_BITS:0]        drx_s1 [sit_pkg::NUM_ORIENT],
	output logic signed [COORD_BITS:0]        dry_s1 [sit_pkg::NUM_ORIENT],
	output sit_pkg::box_t                     box_s1
);

	localparam int D = COORD_BITS + 1;

	// orient(p, q, r) operand points for o1..o4.
	localparam int P_IDX [sit_pkg::NUM_ORIENT] = '{sit_pkg::FLD_A_START,
		sit_pkg::FLD_A_START, sit_pkg::FLD_B_START, sit_pkg::FLD_B_START};
	localparam int Q_IDX [sit_pkg::NUM_ORIENT] = '{sit_pkg::FLD_A_END,
		sit_pkg::FLD_A_END, sit_pkg::FLD_B_END, sit_pkg::FLD_B_END};
	localparam int R_IDX [sit_pkg::NUM_ORIENT] = '{sit_pkg::FLD_B_START,
		sit_pkg::FLD_B_END, sit_pkg::FLD_A_START, sit_pkg::FLD_A_END};

	logic signed [D-1:0] dqx [sit_pkg::NUM_ORIENT];
	logic signed [D-1:0] dqy [sit_pkg::NUM_ORIENT];
	logic signed [D-1:0] drx [sit_pkg::NUM_ORIENT];
	logic signed [D-1:0] dry [sit_pkg::NUM_ORIENT];
	sit_pkg::box_t       box;

	function automatic logic in_span(input logic signed [COORD_BITS-1:0] s,
			input logic signed [COORD_BITS-1:0] t, input logic signed [COORD_BITS-1:0] e);
		in_span = ((t >= s) && (t <= e)) || ((t >= e) && (t <= s));
	endfunction

	function automatic logic in_box(input int s, input int t, input int e);
		logic ok;
		ok = 1'b1;
		for (int a = 0; a < 3; a++) begin
			ok = ok & in_span(crd[s + a], crd[t + a], crd[e + a]);
		end
		in_box = ok;
	endfunction

	always_comb begin
		for (int k = 0; k < sit_pkg::NUM_ORIENT; k++) begin
			dqx[k] = D'(crd[Q_IDX[k] + sit_pkg::AXIS_X]) - D'(crd[P_IDX[k] + sit_pkg::AXIS_X]);
			dqy[k] = D'(crd[Q_IDX[k] + sit_pkg::AXIS_Y]) - D'(crd[P_IDX[k] + sit_pkg::AXIS_Y]);
			drx[k] = D'(crd[R_IDX[k] + sit_pkg::AXIS_X]) - D'(crd[Q_IDX[k] + sit_pkg::AXIS_X]);
			dry[k] = D'(crd[R_IDX[k] + sit_pkg::AXIS_Y]) - D'(crd[Q_IDX[k] + sit_pkg::AXIS_Y]);
		end
		box.bs_in_a = in_box(sit_pkg::FLD_A_START, sit_pkg::FLD_B_START, sit_pkg::FLD_A_END);
		box.be_in_a = in_box(sit_pkg::FLD_A_START, sit_pkg::FLD_B_END, sit_pkg::FLD_A_END);
		box.as_in_b = in_box(sit_pkg::FLD_B_START, sit_pkg::FLD_A_START, sit_pkg::FLD_B_END);
		box.ae_in_b = in_box(sit_pkg::FLD_B_START, sit_pkg::FLD_A_END, sit_pkg::FLD_B_END);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dqx_s1 <= dqx;
			dqy_s1 <= dqy;
			drx_s1 <= drx;
			dry_s1 <= dry;
			box_s1 <= box;
		end
	end

endmodule

`default_nettype wire

[rtl/core/sit_orient.sv]
// Stages two and three: the eight exact cross-product terms, then their
// differences reduced to orientation codes. Depends on sit_pkg.
`default_nettype none

module sit_orient #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  en_s2,
	input  wire logic                  en_s3,
	input  wire logic signed [COORD_BITS:0] dqx_s1 [sit_pkg::NUM_ORIENT],
	input  wire logic signed [COORD_BITS:0] dqy_s1 [sit_pkg::NUM_ORIENT],
	input  wire logic signed [COORD_BITS:0] drx_s1 [sit_pkg::NUM_ORIENT],
	input  wire logic signed [COORD_BITS:0] dry_s1 [sit_pkg::NUM_ORIENT],
	output sit_pkg::orient_set_t       ori_s3
);

	localparam int D = COORD_BITS + 1;
	localparam int PW = 2 * D;
	localparam int XW = PW + 1;

	logic signed [PW-1:0] pa_s2 [sit_pkg::NUM_ORIENT];
	logic signed [PW-1:0] pb_s2 [sit_pkg::NUM_ORIENT];
	logic signed [XW-1:0] xprod [sit_pkg::NUM_ORIENT];
	sit_pkg::ori_t        ori [sit_pkg::NUM_ORIENT];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int k = 0; k < sit_pkg::NUM_ORIENT; k++) begin
				pa_s2[k] <= PW'(dqy_s1[k]) * PW'(drx_s1[k]);
				pb_s2[k] <= PW'(dqx_s1[k]) * PW'(dry_s1[k]);
			end
		end
	end

	// The difference is one bit wider than the products, so its sign is exact.
	always_comb begin
		for (int k = 0; k < sit_pkg::NUM_ORIENT; k++) begin
			xprod[k] = XW'(pa_s2[k]) - XW'(pb_s2[k]);
			if (xprod[k] == '0) begin
				ori[k] = sit_pkg::ORI_COLLINEAR;
			end else if (xprod[k][XW-1]) begin
				ori[k] = sit_pkg::ORI_CCW;
			end else begin
				ori[k] = sit_pkg::ORI_CW;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ori_s3.o1 <= ori[0];
			ori_s3.o2 <= ori[1];
			ori_s3.o3 <= ori[2];
			ori_s3.o4 <= ori[3];
		end
	end

endmodule

`default_nettype wire

[rtl/core/sit_classify.sv]
// Final stage: combines orientations and box flags into the intersect flag
// and the case code, registered as the output stage. Depends on sit_pkg.
`default_nettype none

module sit_classify (
	input  wire logic                  clk,
	input  wire logic                  en_s4,
	input  wire sit_pkg::orient_set_t  ori_s3,
	input  wire sit_pkg::box_t         box_s3,
	output logic                       intersects_s4,
	output sit_pkg::case_t             case_s4
);

	logic          crossing;
	logic          touch;
	logic          hit;
	sit_pkg::case_t code;

	always_comb begin
		crossing = (ori_s3.o1 != ori_s3.o2) && (ori_s3.o3 != ori_s3.o4);
		touch = ((ori_s3.o1 == sit_pkg::ORI_COLLINEAR) && box_s3.bs_in_a) ||
			((ori_s3.o2 == sit_pkg::ORI_COLLINEAR) && box_s3.be_in_a) ||
			((ori_s3.o3 == sit_pkg::ORI_COLLINEAR) && box_s3.as_in_b) ||
			((ori_s3.o4 == sit_pkg::ORI_COLLINEAR) && box_s3.ae_in_b);
		// A proper crossing that also has an endpoint lying on the other
		// segment is rejected rather than reported.
		if (crossing) begin
			hit = !touch;
			code = touch ? sit_pkg::CASE_REJECT : sit_pkg::CASE_CROSS;
		end else begin
			hit = touch;
			code = touch ? sit_pkg::CASE_TOUCH : sit_pkg::CASE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			intersects_s4 <= hit;
			case_s4 <= code;
		end
	end

endmodule

`default_nettype wire

[rtl/core/segment_intersection_test.sv]
// Segment intersection test: one pair of segments per transaction in, one
// result per transaction out, one pair per clock sustained while the output
// accepts results. The depth is set by the exact cross products: stage 1
// forms coordinate differences and box tests, stage 2 the eight multipliers,
// stage 3 the wide subtract and sign, stage 4 the classification and output
// register. Each stage holds its own valid bit and frees itself when the
// stage after it can take its item, so bubbles close up and the input keeps
// flowing while a finished result waits at the output, until every stage
// holds an item. Depends on sit_pkg, sit_front, sit_orient and sit_classify.
`default_nettype none

module segment_intersection_test #(
	parameter int COORD_BITS = 16,
	localparam int IN_W = ((sit_pkg::NUM_FIELDS * COORD_BITS + 7) / 8) * 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	// a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
	// b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z
	input  wire logic [IN_W-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	// intersects, case_code
	output logic [sit_pkg::OUT_W-1:0] m_axis_tdata
);

	logic signed [COORD_BITS-1:0] crd [sit_pkg::NUM_FIELDS];
	logic signed [COORD_BITS:0]   dqx_s1 [sit_pkg::NUM_ORIENT];
	logic signed [COORD_BITS:0]   dqy_s1 [sit_pkg::NUM_ORIENT];
	logic signed [COORD_BITS:0]   drx_s1 [sit_pkg::NUM_ORIENT];
	logic signed [COORD_BITS:0]   dry_s1 [sit_pkg::NUM_ORIENT];
	sit_pkg::box_t                box_s1;
	sit_pkg::box_t                box_s2;
	sit_pkg::box_t                box_s3;
	sit_pkg::orient_set_t         ori_s3;
	logic                         intersects_s4;
	sit_pkg::case_t               case_s4;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	always_comb begin
		for (int k = 0; k < sit_pkg::NUM_FIELDS; k++) begin
			crd[k] = $signed(s_axis_tdata[k*COORD_BITS +: COORD_BITS]);
		end
	end

	assign rdy_s4 = !v_s4 || m_axis_tready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_axis_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Box flags ride alongside the cross-product stages 2 and 3.
	always_ff @(posedge clk) begin
		if (rdy_s2) box_s2 <= box_s1;
		if (rdy_s3) box_s3 <= box_s2;
	end

	sit_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk    (clk),
		.en_s1  (rdy_s1),
		.crd    (crd),
		.dqx_s1 (dqx_s1),
		.dqy_s1 (dqy_s1),
		.drx_s1 (drx_s1),
		.dry_s1 (dry_s1),
		.box_s1 (box_s1)
	);

	sit_orient #(.COORD_BITS(COORD_BITS)) u_orient (
		.clk    (clk),
		.en_s2  (rdy_s2),
		.en_s3  (rdy_s3),
		.dqx_s1 (dqx_s1),
		.dqy_s1 (dqy_s1),
		.drx_s1 (drx_s1),
		.dry_s1 (dry_s1),
		.ori_s3 (ori_s3)
	);

	sit_classify u_classify (
		.clk           (clk),
		.en_s4         (rdy_s4),
		.ori_s3        (ori_s3),
		.box_s3        (box_s3),
		.intersects_s4 (intersects_s4),
		.case_s4       (case_s4)
	);

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata = {(sit_pkg::OUT_W - 3)'(0), case_s4, intersects_s4};

	// The flag must agree with the case code on every delivered result.
	a_flag_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (intersects_s4 ==
			((case_s4 == sit_pkg::CASE_CROSS) || (case_s4 == sit_pkg::CASE_TOUCH))))
		else $error("intersects flag disagrees with case code");

	// A result can only appear if an item sat in the stage before.
	a_out_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s4) |-> $past(v_s3))
		else $error("result appeared without an item in stage 3");

	// A blocked stage keeps its item.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy_s2) |=> v_s1)
		else $error("stage 1 dropped an item while stalled");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rdy_s4) |=> (v_s3 && $stable(ori_s3)))
		else $error("stage 3 lost or changed an item while stalled");

endmodule

`default_nettype wire
